### rtl/box_iou_cost_matrix_macros.svh
// Assertion macros shared by the box IoU cost matrix RTL.
// Used by modules that check their own control logic; no other dependencies.
`ifndef BOX_IOU_COST_MATRIX_MACROS_SVH
`define BOX_IOU_COST_MATRIX_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BIOU_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle control check failed");

// Next-cycle implication, disabled during reset
`define BIOU_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle control check failed");

`endif

### rtl/biou_pkg.sv
// Package for the box IoU cost matrix: widths, action codes and control structs.
// No dependencies; used by every other file of the block but the macros header.
package biou_pkg;

   // Field widths
   localparam int COORD_W  = 16;
   localparam int ACTION_W = 2;
   localparam int INDEX_W  = 5;
   localparam int COST_W   = 17;
   localparam int BOX_W    = 4 * COORD_W;

   // Defaults for top-level parameters
   localparam int MAX_TRACKS_DEF = 32;
   localparam int COORD_FRAC_DEF = 4;

   // Results per query never exceed this many tracks
   localparam int RESULT_LIMIT = 32;

   // Datapath widths
   localparam int EXT_W   = COORD_W + 2;      // extent, one pixel added
   localparam int PROD_W  = 2 * EXT_W;        // signed product
   localparam int INTER_W = 35;               // positive intersection area
   localparam int UNI_W   = PROD_W + 2;       // signed union
   localparam int REM_W   = UNI_W + 1;        // divider remainder

   // IoU of exactly one in Q1.16 and divider length
   localparam logic [COST_W-1:0] IOU_ONE = COST_W'(65536);
   localparam int DIV_STEPS = COST_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR = 2'd0,
      ACT_LOAD  = 2'd1,
      ACT_QUERY = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      MUL_INTER = 2'd0,
      MUL_TRACK = 2'd1,
      MUL_DET   = 2'd2
   } mul_sel_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic rd_en;
   } store_cmd_type;

   typedef struct packed {
      logic        det_load;
      logic        geom_en;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        inter_en;
      logic        acc_en;
      logic        uni_en;
      logic        div_init;
      logic        div_step;
   } dp_cmd_type;

   typedef struct packed {
      logic overlaps;
      logic div_needed;
   } dp_stat_type;

endpackage

### rtl/biou_if.sv
// Valid/ready channel interfaces for the box IoU cost matrix.
// Depends on biou_pkg for the field widths.
interface biou_req_if;
   logic                                valid;
   logic                                ready;
   logic [biou_pkg::ACTION_W-1:0]       action;
   logic signed [biou_pkg::COORD_W-1:0] box_left;
   logic signed [biou_pkg::COORD_W-1:0] box_top;
   logic signed [biou_pkg::COORD_W-1:0] box_right;
   logic signed [biou_pkg::COORD_W-1:0] box_bottom;

   modport source (output valid, action, box_left, box_top, box_right, box_bottom,
                   input ready);
   modport sink   (input valid, action, box_left, box_top, box_right, box_bottom,
                   output ready);
endinterface

interface biou_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [biou_pkg::INDEX_W-1:0] track_index;
   logic [biou_pkg::COST_W-1:0]  cost;
   logic                         overlaps;
   logic                         last_of_run;

   modport source (output valid, track_index, cost, overlaps, last_of_run,
                   input ready);
   modport sink   (input valid, track_index, cost, overlaps, last_of_run,
                   output ready);
endinterface

### rtl/biou_store.sv
// Track box store: box memory with registered read port and fill count.
// Depends on biou_pkg.
module biou_store #(
   parameter int MAX_TRACKS = biou_pkg::MAX_TRACKS_DEF,
   parameter int IDX_W      = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1,
   parameter int CNT_W      = $clog2(MAX_TRACKS + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  biou_pkg::store_cmd_type      cmd,
   input  logic [IDX_W-1:0]             rd_addr,
   input  logic [biou_pkg::BOX_W-1:0]   wr_data,
   output logic [biou_pkg::BOX_W-1:0]   rd_data,
   output logic [CNT_W-1:0]             count
);
   import biou_pkg::*;

   logic [BOX_W-1:0] mem [MAX_TRACKS];
   logic [BOX_W-1:0] rd_data_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             full;
   logic             wr_en;

   assign full  = (count_ff == CNT_W'(MAX_TRACKS));
   assign wr_en = cmd.load && !full;

   // Append at the fill count; drop when full
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[IDX_W-1:0]] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rd_data = rd_data_ff;
   assign count   = count_ff;

endmodule

### rtl/biou_dp.sv
// Shared arithmetic unit: overlap geometry, one shared multiplier, union
// accumulator and a restoring divider producing one quotient bit a cycle.
// Depends on biou_pkg.
module biou_dp #(
   parameter int COORD_FRAC_BITS = biou_pkg::COORD_FRAC_DEF
) (
   input  logic                                clock,
   input  biou_pkg::dp_cmd_type                cmd,
   input  logic signed [biou_pkg::COORD_W-1:0] box_left,
   input  logic signed [biou_pkg::COORD_W-1:0] box_top,
   input  logic signed [biou_pkg::COORD_W-1:0] box_right,
   input  logic signed [biou_pkg::COORD_W-1:0] box_bottom,
   input  logic [biou_pkg::BOX_W-1:0]          track_box,
   output biou_pkg::dp_stat_type               stat,
   output logic [biou_pkg::COST_W-1:0]         iou
);
   import biou_pkg::*;

   localparam logic signed [EXT_W-1:0] ONE = EXT_W'(1) << COORD_FRAC_BITS;

   // Detection box, held for the whole query
   logic signed [COORD_W-1:0] dl_ff, dt_ff, dr_ff, db_ff;
   logic signed [EXT_W-1:0]   dw_ff, dh_ff;

   // Geometry of the current track
   logic signed [COORD_W-1:0] tl, tt, tr, tb;
   logic signed [COORD_W-1:0] min_r, max_l, min_b, max_t;
   logic signed [EXT_W-1:0]   iw, ih, tw, th;
   logic signed [EXT_W-1:0]   iw_ff, ih_ff, tw_ff, th_ff;
   logic                      ov_ff;

   // Multiplier and union
   logic signed [EXT_W-1:0]   mul_a, mul_b;
   logic signed [PROD_W-1:0]  prod_ff;
   logic [INTER_W-1:0]        inter_ff;
   logic signed [UNI_W-1:0]   acc_ff, uni_ff;

   // Divider
   logic [REM_W-1:0]          rem_ff, rem_keep;
   logic [REM_W:0]            diff;
   logic                      q_bit;
   logic [COST_W-1:0]         q_ff;
   logic                      uni_pos, sat;

   assign tl = $signed(track_box[COORD_W-1:0]);
   assign tt = $signed(track_box[2*COORD_W-1:COORD_W]);
   assign tr = $signed(track_box[3*COORD_W-1:2*COORD_W]);
   assign tb = $signed(track_box[4*COORD_W-1:3*COORD_W]);

   assign min_r = (tr < dr_ff) ? tr : dr_ff;
   assign max_l = (tl > dl_ff) ? tl : dl_ff;
   assign min_b = (tb < db_ff) ? tb : db_ff;
   assign max_t = (tt > dt_ff) ? tt : dt_ff;

   assign iw = EXT_W'(min_r) - EXT_W'(max_l) + ONE;
   assign ih = EXT_W'(min_b) - EXT_W'(max_t) + ONE;
   assign tw = EXT_W'(tr) - EXT_W'(tl) + ONE;
   assign th = EXT_W'(tb) - EXT_W'(tt) + ONE;

   // Select multiplier operands
   always_comb begin
      case (cmd.mul_sel)
         MUL_INTER: begin mul_a = iw_ff; mul_b = ih_ff; end
         MUL_TRACK: begin mul_a = tw_ff; mul_b = th_ff; end
         MUL_DET:   begin mul_a = dw_ff; mul_b = dh_ff; end
         default:   begin mul_a = iw_ff; mul_b = ih_ff; end
      endcase
   end

   // Positive union, and whether the quotient would reach 2.0 (saturate)
   assign uni_pos = !uni_ff[UNI_W-1] && (uni_ff != '0);
   assign sat     = REM_W'(inter_ff) >= {uni_ff, 1'b0};

   // One restoring step: subtract, keep or restore, then double
   assign diff     = {1'b0, rem_ff} - {2'b00, uni_ff};
   assign q_bit    = !diff[REM_W];
   assign rem_keep = q_bit ? diff[REM_W-1:0] : rem_ff;

   always_ff @(posedge clock) begin
      if (cmd.det_load) begin
         dl_ff <= box_left;
         dt_ff <= box_top;
         dr_ff <= box_right;
         db_ff <= box_bottom;
         dw_ff <= EXT_W'(box_right) - EXT_W'(box_left) + ONE;
         dh_ff <= EXT_W'(box_bottom) - EXT_W'(box_top) + ONE;
      end
      if (cmd.geom_en) begin
         iw_ff <= iw;
         ih_ff <= ih;
         tw_ff <= tw;
         th_ff <= th;
         ov_ff <= !iw[EXT_W-1] && (iw != '0) && !ih[EXT_W-1] && (ih != '0);
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.inter_en) begin
         inter_ff <= prod_ff[INTER_W-1:0];
      end
      if (cmd.acc_en) begin
         acc_ff <= UNI_W'(prod_ff) - $signed(UNI_W'(inter_ff));
      end
      if (cmd.uni_en) begin
         uni_ff <= acc_ff + UNI_W'(prod_ff);
      end
      // Quotient starts at zero per track; preset on saturation
      if (cmd.geom_en) begin
         q_ff <= '0;
      end else if (cmd.div_init) begin
         rem_ff <= REM_W'(inter_ff);
         q_ff   <= (uni_pos && sat) ? IOU_ONE : '0;
      end else if (cmd.div_step) begin
         rem_ff <= {rem_keep[REM_W-2:0], 1'b0};
         q_ff   <= {q_ff[COST_W-2:0], q_bit};
      end
   end

   assign stat.overlaps   = ov_ff;
   assign stat.div_needed = uni_pos && !sat;
   assign iou             = q_ff;

endmodule

### rtl/biou_ctrl.sv
// Sequencer: decodes actions, walks stored tracks and steps the shared unit.
// Depends on biou_pkg and box_iou_cost_matrix_macros.svh.
`include "box_iou_cost_matrix_macros.svh"

module biou_ctrl #(
   parameter int MAX_TRACKS = biou_pkg::MAX_TRACKS_DEF,
   parameter int IDX_W      = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1,
   parameter int CNT_W      = $clog2(MAX_TRACKS + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic [biou_pkg::ACTION_W-1:0]  action,
   output logic                           req_ready,
   input  logic [CNT_W-1:0]               count,
   output biou_pkg::store_cmd_type        store_cmd,
   output logic [IDX_W-1:0]               track_addr,
   output biou_pkg::dp_cmd_type           dp_cmd,
   input  biou_pkg::dp_stat_type          dp_stat,
   input  logic                           out_free,
   output logic                           out_load,
   output logic                           last
);
   import biou_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b00_0000_0001,
      S_READ  = 10'b00_0000_0010,
      S_GEOM  = 10'b00_0000_0100,
      S_MUL_I = 10'b00_0000_1000,
      S_MUL_T = 10'b00_0001_0000,
      S_MUL_D = 10'b00_0010_0000,
      S_UNION = 10'b00_0100_0000,
      S_CHECK = 10'b00_1000_0000,
      S_DIV   = 10'b01_0000_0000,
      S_OUT   = 10'b10_0000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     k_ff, k_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 accept;

   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   assign track_addr = k_ff;
   assign last       = ((CNT_W'(k_ff) + CNT_W'(1)) == n_ff);

   always_comb begin
      state_in        = state_ff;
      k_in            = k_ff;
      n_in            = n_ff;
      cnt_in          = cnt_ff;
      store_cmd       = '0;
      dp_cmd          = '0;
      dp_cmd.mul_sel  = MUL_INTER;
      out_load        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (action)
                  ACT_CLEAR: store_cmd.clear = 1'b1;
                  ACT_LOAD:  store_cmd.load  = 1'b1;
                  ACT_QUERY: begin
                     dp_cmd.det_load = 1'b1;
                     k_in = '0;
                     n_in = (32'(count) > RESULT_LIMIT) ? CNT_W'(RESULT_LIMIT) : count;
                     if (count != '0) begin
                        state_in = S_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            store_cmd.rd_en = 1'b1;
            state_in = S_GEOM;
         end
         S_GEOM: begin
            dp_cmd.geom_en = 1'b1;
            state_in = S_MUL_I;
         end
         S_MUL_I: begin
            dp_cmd.mul_en  = 1'b1;
            dp_cmd.mul_sel = MUL_INTER;
            // No overlap: IoU stays zero
            state_in = dp_stat.overlaps ? S_MUL_T : S_OUT;
         end
         S_MUL_T: begin
            dp_cmd.mul_en   = 1'b1;
            dp_cmd.mul_sel  = MUL_TRACK;
            dp_cmd.inter_en = 1'b1;
            state_in = S_MUL_D;
         end
         S_MUL_D: begin
            dp_cmd.mul_en  = 1'b1;
            dp_cmd.mul_sel = MUL_DET;
            dp_cmd.acc_en  = 1'b1;
            state_in = S_UNION;
         end
         S_UNION: begin
            dp_cmd.uni_en = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            dp_cmd.div_init = 1'b1;
            cnt_in = '0;
            state_in = dp_stat.div_needed ? S_DIV : S_OUT;
         end
         S_DIV: begin
            dp_cmd.div_step = 1'b1;
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // Hand the result to the output register, then advance
            if (out_free) begin
               out_load = 1'b1;
               k_in = k_ff + IDX_W'(1);
               state_in = last ? S_IDLE : S_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= '0;
         n_ff     <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         n_ff     <= n_in;
         cnt_ff   <= cnt_in;
      end
   end

   `BIOU_ASSERT_IMP(a_read_in_run, clock, reset, state_ff == S_READ, CNT_W'(k_ff) < n_ff)
   `BIOU_ASSERT_IMP(a_div_bound, clock, reset, state_ff == S_DIV, cnt_ff < DIV_CNT_W'(DIV_STEPS))
   `BIOU_ASSERT_NXT(a_last_ends_run, clock, reset, out_load && last, state_ff == S_IDLE)
   `BIOU_ASSERT_NXT(a_empty_query, clock, reset, accept && (action == ACT_QUERY) && (count == '0), state_ff == S_IDLE)

endmodule

### rtl/box_iou_cost_matrix.sv
// Box IoU cost matrix: keeps track boxes and returns 1 - IoU per stored track.
// Channels: req_ch (sink) takes clear, load and query items; rsp_ch (source)
// gives one result per stored track on a query, up to RESULT_LIMIT, in store
// order, with last_of_run on the final one. Clear and load give no result;
// a load into a full store is dropped.
// A query walks the tracks one at a time through a single shared unit:
// memory read, geometry, three products on one 18x18 multiplier, union, and
// a 17-step restoring divider. When the boxes do not overlap the later
// products, union and divider are skipped; when the union is not positive or
// the IoU saturates the divider is skipped. req_ch.ready stays low until the
// last result is in the output register. The divider gives one quotient bit
// a cycle.
// Results wait in a one-deep output register; while rsp_ch is stalled the
// sequencer holds with the next result ready and resumes on the transfer.
// Reset is synchronous and active high: the store is empty, no result is
// pending and the block is ready. Box memory contents are not cleared.
// Depends on biou_pkg, biou_if, biou_store, biou_dp and biou_ctrl.
module box_iou_cost_matrix #(
   parameter int MAX_TRACKS      = biou_pkg::MAX_TRACKS_DEF,
   parameter int COORD_FRAC_BITS = biou_pkg::COORD_FRAC_DEF
) (
   input logic       clock,
   input logic       reset,
   biou_req_if.sink   req_ch,
   biou_rsp_if.source rsp_ch
);
   import biou_pkg::*;

   localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
   localparam int CNT_W = $clog2(MAX_TRACKS + 1);

   store_cmd_type     store_cmd;
   dp_cmd_type        dp_cmd;
   dp_stat_type       dp_stat;
   logic [IDX_W-1:0]  track_addr;
   logic [BOX_W-1:0]  track_box;
   logic [CNT_W-1:0]  count;
   logic [COST_W-1:0] iou;
   logic              out_free;
   logic              out_load;
   logic              last;

   // Output register
   logic               rsp_valid_ff;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic [COST_W-1:0]  rsp_cost_ff;
   logic               rsp_ov_ff;
   logic               rsp_last_ff;

   biou_ctrl #(
      .MAX_TRACKS (MAX_TRACKS),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .action     (req_ch.action),
      .req_ready  (req_ch.ready),
      .count      (count),
      .store_cmd  (store_cmd),
      .track_addr (track_addr),
      .dp_cmd     (dp_cmd),
      .dp_stat    (dp_stat),
      .out_free   (out_free),
      .out_load   (out_load),
      .last       (last)
   );

   biou_store #(
      .MAX_TRACKS (MAX_TRACKS),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (store_cmd),
      .rd_addr (track_addr),
      .wr_data ({req_ch.box_bottom, req_ch.box_right, req_ch.box_top, req_ch.box_left}),
      .rd_data (track_box),
      .count   (count)
   );

   biou_dp #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .cmd        (dp_cmd),
      .box_left   (req_ch.box_left),
      .box_top    (req_ch.box_top),
      .box_right  (req_ch.box_right),
      .box_bottom (req_ch.box_bottom),
      .track_box  (track_box),
      .stat       (dp_stat),
      .iou        (iou)
   );

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // Hold a result until its transfer; refill in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_index_ff <= INDEX_W'(track_addr);
         rsp_cost_ff  <= IOU_ONE - iou;
         rsp_ov_ff    <= dp_stat.overlaps;
         rsp_last_ff  <= last;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.track_index = rsp_index_ff;
   assign rsp_ch.cost        = rsp_cost_ff;
   assign rsp_ch.overlaps    = rsp_ov_ff;
   assign rsp_ch.last_of_run = rsp_last_ff;

endmodule
